// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is asserted
`define CSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define CSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/csp_pkg.sv
package csp_pkg;

  // Fixed point format and multiplier slicing
  localparam int FRAC_BITS    = 16;
  localparam int MUL_CHUNK    = 16;
  localparam int HORNER_STEPS = 3;

  // Fixed field widths
  localparam int ENTRY_W      = 6;
  localparam int SEG_OUT_W    = 6;
  localparam int KNOT_COUNT_W = 7;
  localparam logic [KNOT_COUNT_W-1:0] KNOT_COUNT_RST = 7'd2;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_KNOT_COUNT = 1'b0;

  // Transaction kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEARCH,
    ST_CALC,
    ST_DONE
  } csp_state_t;

  // Horner unit phases
  typedef enum logic [2:0] {
    HP_IDLE,
    HP_MUL,
    HP_RND,
    HP_ADD,
    HP_FIN
  } csp_hphase_t;

  // Horner unit status toward the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } csp_hstat_t;

endpackage

// File: design/csp_table.sv
module csp_table #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_KNOTS  = 64,
  localparam int AW = $clog2(MAX_KNOTS)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [VALUE_BITS-1:0] wr_knot,
  input  logic signed [VALUE_BITS-1:0] wr_a,
  input  logic signed [VALUE_BITS-1:0] wr_b,
  input  logic signed [VALUE_BITS-1:0] wr_c,
  input  logic signed [VALUE_BITS-1:0] wr_d,
  input  logic [AW-1:0]                rd_addr,
  input  logic [AW-1:0]                rd_addr_nx,
  output logic signed [VALUE_BITS-1:0] rd_knot,
  output logic signed [VALUE_BITS-1:0] rd_knot_nx,
  output logic signed [VALUE_BITS-1:0] rd_a,
  output logic signed [VALUE_BITS-1:0] rd_b,
  output logic signed [VALUE_BITS-1:0] rd_c,
  output logic signed [VALUE_BITS-1:0] rd_d
);

  logic signed [VALUE_BITS-1:0] knot_mem [MAX_KNOTS];
  logic signed [VALUE_BITS-1:0] a_mem    [MAX_KNOTS];
  logic signed [VALUE_BITS-1:0] b_mem    [MAX_KNOTS];
  logic signed [VALUE_BITS-1:0] c_mem    [MAX_KNOTS];
  logic signed [VALUE_BITS-1:0] d_mem    [MAX_KNOTS];

  // One write port; knot memory has a second read port for the next knot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      knot_mem[wr_addr] <= wr_knot;
      a_mem[wr_addr]    <= wr_a;
      b_mem[wr_addr]    <= wr_b;
      c_mem[wr_addr]    <= wr_c;
      d_mem[wr_addr]    <= wr_d;
    end
    rd_knot    <= knot_mem[rd_addr];
    rd_knot_nx <= knot_mem[rd_addr_nx];
    rd_a       <= a_mem[rd_addr];
    rd_b       <= b_mem[rd_addr];
    rd_c       <= c_mem[rd_addr];
    rd_d       <= d_mem[rd_addr];
  end

endmodule

// File: design/csp_horner.sv
module csp_horner
  import csp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [VALUE_BITS:0]   t_in,
  input  logic signed [VALUE_BITS-1:0] a_in,
  input  logic signed [VALUE_BITS-1:0] b_in,
  input  logic signed [VALUE_BITS-1:0] c_in,
  input  logic signed [VALUE_BITS-1:0] d_in,
  output logic signed [VALUE_BITS-1:0] y_out,
  output csp_hstat_t                   stat
);

  localparam int VB  = VALUE_BITS;
  localparam int NCH = (VB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int RW  = NCH * MUL_CHUNK;
  localparam int PW  = VB + 1 + RW;
  localparam int CNW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [PW-1:0] LIM_POS = (PW'(1) << (VB - 1)) - PW'(1);
  localparam logic [PW-1:0] RND_ADD = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
  localparam logic [1:0] LAST_STAGE = 2'(HORNER_STEPS - 1);

  csp_hphase_t phase_r, phase_nxt;

  logic [1:0]            stage_r;
  logic [CNW-1:0]        chunk_r;
  logic [VB:0]           tmag_r;
  logic                  tneg_r;
  logic [RW-1:0]         rmag_r;
  logic                  pneg_r;
  logic [PW-1:0]         acc_r;
  logic signed [VB-1:0]  pv_r;
  logic signed [VB-1:0]  r_r;
  logic                  ovf_r;
  logic signed [VB-1:0]  a_r, b_r, c_r;

  logic [VB+MUL_CHUNK:0] prod;
  logic [PW-1:0]         rnd;
  logic [PW-1:0]         q;
  logic                  q_sat;
  logic [VB-1:0]         qv;
  logic signed [VB-1:0]  pv;
  logic signed [VB-1:0]  coef;
  logic signed [VB:0]    sum;
  logic                  sum_sat;
  logic signed [VB-1:0]  r_new;

  function automatic logic [VB-1:0] mag(input logic signed [VB-1:0] v);
    return v[VB-1] ? VB'(-v) : VB'(v);
  endfunction

  // One slice of the magnitude product, most significant slice first
  assign prod = tmag_r * rmag_r[RW-1 -: MUL_CHUNK];

  // Round to nearest (ties away from zero) on the magnitude, then saturate
  assign rnd   = acc_r + RND_ADD;
  assign q     = rnd >> FRAC_BITS;
  assign q_sat = q > (LIM_POS + PW'(pneg_r));
  assign qv    = q[VB-1:0];
  always_comb begin
    if (q_sat) begin
      pv = pneg_r ? VMIN : VMAX;
    end else begin
      pv = pneg_r ? $signed(VB'(-qv)) : $signed(qv);
    end
  end

  // Coefficient added at each step
  always_comb begin
    case (stage_r)
      2'd0:    coef = c_r;
      2'd1:    coef = b_r;
      default: coef = a_r;
    endcase
  end

  assign sum     = {coef[VB-1], coef} + {pv_r[VB-1], pv_r};
  assign sum_sat = sum[VB] != sum[VB-1];
  assign r_new   = sum_sat ? (sum[VB] ? VMIN : VMAX) : sum[VB-1:0];

  // Phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= HP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      HP_IDLE: if (start) phase_nxt = HP_MUL;
      HP_MUL:  if (chunk_r == CNW'(NCH - 1)) phase_nxt = HP_RND;
      HP_RND:  phase_nxt = HP_ADD;
      HP_ADD:  phase_nxt = (stage_r == LAST_STAGE) ? HP_FIN : HP_MUL;
      HP_FIN:  phase_nxt = HP_IDLE;
      default: phase_nxt = HP_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    stat.done = (phase_r == HP_FIN);
    stat.ovf  = ovf_r;
    y_out     = r_r;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (phase_r)
      HP_IDLE: begin
        if (start) begin
          tmag_r  <= t_in[VB] ? (VB+1)'(-t_in) : (VB+1)'(t_in);
          tneg_r  <= t_in[VB];
          rmag_r  <= RW'(mag(d_in));
          pneg_r  <= t_in[VB] ^ d_in[VB-1];
          acc_r   <= '0;
          chunk_r <= '0;
          stage_r <= '0;
          ovf_r   <= 1'b0;
          a_r     <= a_in;
          b_r     <= b_in;
          c_r     <= c_in;
          r_r     <= d_in;
        end
      end
      HP_MUL: begin
        acc_r   <= (acc_r << MUL_CHUNK) + PW'(prod);
        rmag_r  <= rmag_r << MUL_CHUNK;
        chunk_r <= chunk_r + CNW'(1);
      end
      HP_RND: begin
        pv_r <= pv;
        if (q_sat) ovf_r <= 1'b1;
      end
      HP_ADD: begin
        r_r     <= r_new;
        rmag_r  <= RW'(mag(r_new));
        pneg_r  <= tneg_r ^ r_new[VB-1];
        acc_r   <= '0;
        chunk_r <= '0;
        stage_r <= stage_r + 2'd1;
        if (sum_sat) ovf_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/cubic_spline_evaluator.sv
// Evaluate transaction: S search steps, each one knot memory read and compare, then Horner
// evaluation, each Horner step using the shared multiply unit one MUL_CHUNK slice at a time.
// An evaluate keeps the input busy until its result enters the result register; loads are
// taken one per cycle while the sequencer is idle.
// Reset (rst_n, synchronous): sequencer idle, knot_count = 2, search position 0; table memories
// keep their contents and are not cleared.
module cubic_spline_evaluator
  import csp_pkg::*;
#(
  parameter int MAX_KNOTS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [ENTRY_W-1:0]           in_entry_index,
  input  logic signed [VALUE_BITS-1:0] in_knot_value,
  input  logic signed [VALUE_BITS-1:0] in_coef_const,
  input  logic signed [VALUE_BITS-1:0] in_coef_linear,
  input  logic signed [VALUE_BITS-1:0] in_coef_square,
  input  logic signed [VALUE_BITS-1:0] in_coef_cube,
  input  logic signed [VALUE_BITS-1:0] in_x_value,
  input  logic                         in_last_in_batch,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_y_value,
  output logic [SEG_OUT_W-1:0]         out_segment_used,
  output logic                         out_overflow,
  output logic                         out_last_out,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_AW-1:0]            paddr,
  input  logic [CFG_DW-1:0]            pwdata,
  output logic [CFG_DW-1:0]            prdata,
  output logic                         pready
);

  localparam int VB  = VALUE_BITS;
  localparam int AW  = $clog2(MAX_KNOTS);
  localparam int IW  = (AW > ENTRY_W) ? AW : ENTRY_W;
  localparam int SXW = (AW > SEG_OUT_W) ? AW : SEG_OUT_W;
  localparam int LW  = (AW + 1 > KNOT_COUNT_W) ? AW + 1 : KNOT_COUNT_W;

  csp_state_t state_r, state_nxt;

  logic [KNOT_COUNT_W-1:0] knot_count_r;
  logic [AW-1:0]           seg_r;
  logic [AW-1:0]           search_seg_r;
  logic signed [VB-1:0]    x_r;
  logic                    last_r;
  logic signed [VB-1:0]    k0_r, k1_r;

  logic                    out_valid_r;
  logic signed [VB-1:0]    out_y_r;
  logic [SEG_OUT_W-1:0]    out_seg_r;
  logic                    out_ovf_r;
  logic                    out_last_r;

  logic                    in_fire;
  logic [IW-1:0]           idx_ext;
  logic                    tbl_wr;
  logic [AW-1:0]           wr_addr;
  logic [LW-1:0]           kc_ext;
  logic [LW-1:0]           kc_cl;
  logic [AW-1:0]           last_seg;
  logic                    desc;
  logic                    adv;
  logic                    restart;
  logic                    h_start;
  logic                    out_load;
  logic signed [VB:0]      t_val;
  logic [SXW-1:0]          seg_ext;
  logic                    cfg_wr;

  logic signed [VB-1:0]    rd_knot, rd_knot_nx, rd_a, rd_b, rd_c, rd_d;
  logic signed [VB-1:0]    h_y;
  csp_hstat_t              h_stat;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KNOT_COUNT);
  assign prdata = (paddr[2] == REG_KNOT_COUNT) ? CFG_DW'(knot_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= KNOT_COUNT_RST;
    end else if (cfg_wr) begin
      knot_count_r <= pwdata[KNOT_COUNT_W-1:0];
    end
  end

  // Last segment from the clamped knot count
  assign kc_ext   = LW'(knot_count_r);
  assign kc_cl    = (kc_ext < LW'(2)) ? LW'(2) :
                    (kc_ext > LW'(MAX_KNOTS)) ? LW'(MAX_KNOTS) : kc_ext;
  assign last_seg = AW'(kc_cl - LW'(2));

  // Load address decode; one extra bit so the table depth itself fits
  assign in_fire = in_valid && in_ready;
  assign idx_ext = IW'(in_entry_index);
  assign wr_addr = idx_ext[AW-1:0];
  assign tbl_wr  = in_fire && (in_mode == MODE_LOAD) &&
                   ({1'b0, idx_ext} < (IW+1)'(MAX_KNOTS));

  // Search direction follows the first two knots
  assign desc = k1_r < k0_r;

  // Search step decisions on the knots read for seg_r
  always_comb begin
    adv     = (seg_r < last_seg) && (desc ? (x_r <= rd_knot_nx) : (x_r >= rd_knot_nx));
    restart = !adv && (seg_r != '0) && (desc ? (x_r > rd_knot) : (x_r < rd_knot));
  end

  assign t_val = {x_r[VB-1], x_r} - {rd_knot[VB-1], rd_knot};

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid && (in_mode == MODE_EVAL)) state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = ST_SEARCH;
      ST_SEARCH: state_nxt = (adv || restart) ? ST_FETCH : ST_CALC;
      ST_CALC:   if (h_stat.done) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    h_start  = (state_r == ST_SEARCH) && !adv && !restart;
    out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  // Search position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r        <= '0;
      search_seg_r <= '0;
    end else begin
      if (in_fire && (in_mode == MODE_EVAL)) begin
        seg_r <= (search_seg_r > last_seg) ? '0 : search_seg_r;
      end else if (state_r == ST_SEARCH) begin
        if (adv) begin
          seg_r <= seg_r + AW'(1);
        end else if (restart) begin
          seg_r <= '0;
        end
      end
      if (h_start) begin
        search_seg_r <= last_r ? '0 : seg_r;
      end
    end
  end

  // Point under evaluation and shadow copies of the first two knots
  always_ff @(posedge clk) begin
    if (in_fire && (in_mode == MODE_EVAL)) begin
      x_r    <= in_x_value;
      last_r <= in_last_in_batch;
    end
    if (tbl_wr && (wr_addr == AW'(0))) k0_r <= in_knot_value;
    if (tbl_wr && (wr_addr == AW'(1))) k1_r <= in_knot_value;
  end

  // Result register
  assign seg_ext = SXW'(seg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_y_r    <= h_y;
      out_seg_r  <= seg_ext[SEG_OUT_W-1:0];
      out_ovf_r  <= h_stat.ovf;
      out_last_r <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_y_value      = out_y_r;
  assign out_segment_used = out_seg_r;
  assign out_overflow     = out_ovf_r;
  assign out_last_out     = out_last_r;

  csp_table #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_KNOTS  (MAX_KNOTS)
  ) u_table (
    .clk        (clk),
    .wr_en      (tbl_wr),
    .wr_addr    (wr_addr),
    .wr_knot    (in_knot_value),
    .wr_a       (in_coef_const),
    .wr_b       (in_coef_linear),
    .wr_c       (in_coef_square),
    .wr_d       (in_coef_cube),
    .rd_addr    (seg_r),
    .rd_addr_nx (seg_r + AW'(1)),
    .rd_knot    (rd_knot),
    .rd_knot_nx (rd_knot_nx),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .rd_c       (rd_c),
    .rd_d       (rd_d)
  );

  csp_horner #(
    .VALUE_BITS (VALUE_BITS)
  ) u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .t_in  (t_val),
    .a_in  (rd_a),
    .b_in  (rd_b),
    .c_in  (rd_c),
    .d_in  (rd_d),
    .y_out (h_y),
    .stat  (h_stat)
  );

endmodule

// File: design/csp_checker.sv
`include "assert_macros.svh"

module csp_checker
  import csp_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_mode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] out_y_value,
  input logic [SEG_OUT_W-1:0]         out_segment_used,
  input logic                         out_overflow,
  input logic                         out_last_out
);

  // No result is offered right after reset
  `CSP_ASSERT_RST(a_rst_no_result, !rst_n |=> !out_valid, "result valid after reset")

  // An evaluate transaction keeps the block busy in the following cycle
  `CSP_ASSERT(a_eval_busy, in_valid && in_ready && (in_mode == MODE_EVAL) |=> !in_ready, "evaluate did not occupy the block")

  // A load transaction into an idle block produces no result
  `CSP_ASSERT(a_load_silent, in_valid && in_ready && (in_mode == MODE_LOAD) && !out_valid |=> !out_valid, "load produced a result")

  // A stalled result holds
  `CSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_y_value) && $stable(out_segment_used) && $stable(out_overflow) && $stable(out_last_out), "stalled result changed")

endmodule

bind cubic_spline_evaluator csp_checker #(.VALUE_BITS(VALUE_BITS)) u_csp_checker (.*);

// File: dv/cubic_spline_evaluator_tb.sv
module cubic_spline_evaluator_tb;
  import csp_pkg::*;

  localparam int VB           = 32;
  localparam int NK           = 64;
  localparam int DRAIN_CYCLES = 160;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [CFG_AW-1:0] KNOT_COUNT_ADDR = CFG_AW'(4 * REG_KNOT_COUNT);

  localparam logic signed [127:0] Q_MAX = (128'sd1 <<< (VB - 1)) - 128'sd1;
  localparam logic signed [127:0] Q_MIN = -(128'sd1 <<< (VB - 1));
  localparam logic signed [VB-1:0] FX_ONE = 32'sh0001_0000;
  localparam logic signed [VB-1:0] FX_MAX = 32'sh7fff_ffff;
  localparam logic signed [VB-1:0] FX_MIN = 32'sh8000_0000;

  typedef struct {
    logic                  mode;
    logic [ENTRY_W-1:0]    idx;
    logic signed [VB-1:0]  knot;
    logic signed [VB-1:0]  a;
    logic signed [VB-1:0]  b;
    logic signed [VB-1:0]  c;
    logic signed [VB-1:0]  d;
    logic signed [VB-1:0]  x;
    logic                  last;
  } spline_item_t;

  typedef struct {
    logic signed [VB-1:0]  y;
    logic [SEG_OUT_W-1:0]  seg;
    logic                  ovf;
    logic                  last;
  } point_result_t;

  typedef enum {ORD_ASC, ORD_DESC, ORD_EQ_FIRST, ORD_SCRAMBLED} table_order_t;

  // DUT signals
  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_mode = MODE_LOAD;
  logic [ENTRY_W-1:0]    in_entry_index = '0;
  logic signed [VB-1:0]  in_knot_value = '0;
  logic signed [VB-1:0]  in_coef_const = '0;
  logic signed [VB-1:0]  in_coef_linear = '0;
  logic signed [VB-1:0]  in_coef_square = '0;
  logic signed [VB-1:0]  in_coef_cube = '0;
  logic signed [VB-1:0]  in_x_value = '0;
  logic                  in_last_in_batch = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [VB-1:0]  out_y_value;
  logic [SEG_OUT_W-1:0]  out_segment_used;
  logic                  out_overflow;
  logic                  out_last_out;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_AW-1:0]     paddr = '0;
  logic [CFG_DW-1:0]     pwdata = '0;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  // Predictor state
  logic signed [VB-1:0]      knot_tab   [NK];
  logic signed [VB-1:0]      coef_a_tab [NK];
  logic signed [VB-1:0]      coef_b_tab [NK];
  logic signed [VB-1:0]      coef_c_tab [NK];
  logic signed [VB-1:0]      coef_d_tab [NK];
  logic [SEG_OUT_W-1:0]      search_seg = '0;
  logic [KNOT_COUNT_W-1:0]   knot_count_reg = KNOT_COUNT_RST;

  spline_item_t  spline_items[$];
  point_result_t predicted_points[$];
  spline_item_t  tx_item;

  int  queued_items = 0;
  int  accepted_items = 0;
  int  n_loads = 0;
  int  n_evals = 0;
  int  n_results = 0;
  int  n_saturated = 0;
  int  n_settings = 0;
  int  n_errors = 0;
  int  tx_gap = 0;
  bit  tx_rush = 1'b0;
  int  rx_wait = 0;
  int  rx_hold = 0;
  bit  rx_hold_done = 1'b0;
  bit  rx_rush = 1'b0;

  // Stimulus generator state
  longint gen_knot [NK];
  longint gen_lo, gen_hi, step_max;
  bit     gen_desc;

  cubic_spline_evaluator #(
    .MAX_KNOTS  (NK),
    .VALUE_BITS (VB)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_entry_index   (in_entry_index),
    .in_knot_value    (in_knot_value),
    .in_coef_const    (in_coef_const),
    .in_coef_linear   (in_coef_linear),
    .in_coef_square   (in_coef_square),
    .in_coef_cube     (in_coef_cube),
    .in_x_value       (in_x_value),
    .in_last_in_batch (in_last_in_batch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_y_value      (out_y_value),
    .out_segment_used (out_segment_used),
    .out_overflow     (out_overflow),
    .out_last_out     (out_last_out),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Count below 2 acts as 2, above the table depth as the depth
  function automatic int active_knots(input logic [KNOT_COUNT_W-1:0] v);
    if (v < 2) return 2;
    if (v > NK) return NK;
    return int'(v);
  endfunction

  // Search key: knots are mirrored for a descending table
  function automatic longint knot_key(input int k, input bit desc);
    longint kv;
    kv = knot_tab[k];
    return desc ? -kv : kv;
  endfunction

  // Exact product rounded to Q.16, nearest with ties away from zero
  function automatic logic signed [127:0] round_mul(input logic signed [127:0] a,
                                                    input logic signed [127:0] b);
    logic signed [127:0] p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + 128'sd32768) >>> FRAC_BITS;
    return (p < 0) ? -m : m;
  endfunction

  function automatic logic signed [VB-1:0] sat_q(input logic signed [127:0] v);
    if (v > Q_MAX) return FX_MAX;
    if (v < Q_MIN) return FX_MIN;
    return VB'(v);
  endfunction

  // Segment search plus Horner evaluation; updates the kept search position
  function automatic point_result_t evaluate_point(input logic signed [VB-1:0] x,
                                                   input logic last);
    point_result_t       res;
    int                  lastseg, s;
    bit                  desc, done, ovf;
    longint              xc;
    logic signed [127:0] t, w;
    logic signed [VB-1:0] r, cf;
    lastseg = active_knots(knot_count_reg) - 2;
    desc = knot_tab[1] < knot_tab[0];
    xc = desc ? -longint'(x) : longint'(x);
    s = int'(search_seg);
    if (s > lastseg) s = 0;
    done = 1'b0;
    while (!done) begin
      if (s < lastseg && xc >= knot_key(s + 1, desc)) s++;
      else if (s > 0 && xc < knot_key(s, desc)) s = 0;
      else done = 1'b1;
    end
    search_seg = last ? '0 : SEG_OUT_W'(s);

    t = longint'(x) - longint'(knot_tab[s]);
    r = coef_d_tab[s];
    ovf = 1'b0;
    for (int st = 0; st < HORNER_STEPS; st++) begin
      case (st)
        0: cf = coef_c_tab[s];
        1: cf = coef_b_tab[s];
        default: cf = coef_a_tab[s];
      endcase
      w = round_mul(t, r);
      ovf |= (w != sat_q(w));
      w = cf + sat_q(w);
      ovf |= (w != sat_q(w));
      r = sat_q(w);
    end
    res.y = r;
    res.seg = SEG_OUT_W'(s);
    res.ovf = ovf;
    res.last = last;
    return res;
  endfunction

  // Predictor update for one accepted input transaction
  function automatic void apply_item(input spline_item_t it);
    if (it.mode == MODE_LOAD) begin
      knot_tab[it.idx] = it.knot;
      coef_a_tab[it.idx] = it.a;
      coef_b_tab[it.idx] = it.b;
      coef_c_tab[it.idx] = it.c;
      coef_d_tab[it.idx] = it.d;
      n_loads++;
    end else begin
      predicted_points.push_back(evaluate_point(it.x, it.last));
      n_evals++;
    end
  endfunction

  // Random value spread over +/- 2^(bits-1)
  function automatic logic signed [VB-1:0] rand_q(input int bits);
    logic signed [VB-1:0] v;
    v = $urandom;
    return v >>> (VB - bits);
  endfunction

  function automatic void queue_load(input int idx, input logic signed [VB-1:0] kn, a, b, c, d);
    spline_item_t it;
    it.mode = MODE_LOAD;
    it.idx = ENTRY_W'(idx);
    it.knot = kn;
    it.a = a;
    it.b = b;
    it.c = c;
    it.d = d;
    it.x = $urandom;
    it.last = 1'($urandom_range(0, 1));
    spline_items.push_back(it);
    queued_items++;
  endfunction

  function automatic void queue_eval(input logic signed [VB-1:0] x, input logic last);
    spline_item_t it;
    it.mode = MODE_EVAL;
    it.idx = ENTRY_W'($urandom);
    it.knot = $urandom;
    it.a = $urandom;
    it.b = $urandom;
    it.c = $urandom;
    it.d = $urandom;
    it.x = x;
    it.last = last;
    spline_items.push_back(it);
    queued_items++;
  endfunction

  // Write entries 0..k-1 with knots in the given order
  function automatic void fill_table(input int k, input table_order_t order, input int cbits);
    longint pos;
    step_max = longint'(1) << $urandom_range(10, 18);
    pos = -(longint'(k) * step_max) / 2;
    gen_lo = 64'sh7fff_ffff_ffff_ffff;
    gen_hi = -gen_lo;
    for (int i = 0; i < k; i++) begin
      if (order == ORD_SCRAMBLED) gen_knot[i] = longint'(rand_q(VB));
      else gen_knot[i] = (order == ORD_DESC) ? -pos : pos;
      if (!(order == ORD_EQ_FIRST && i == 0)) pos += $urandom_range(1, int'(step_max));
      if (gen_knot[i] < gen_lo) gen_lo = gen_knot[i];
      if (gen_knot[i] > gen_hi) gen_hi = gen_knot[i];
      queue_load(i, VB'(gen_knot[i]), rand_q(cbits), rand_q(cbits), rand_q(cbits),
                 rand_q(cbits));
    end
    gen_desc = (order == ORD_DESC);
  endfunction

  // Batch of points swept along the table direction, usually closed by a last mark
  function automatic void queue_batch(input int n, input bit close);
    longint x, stride;
    stride = (gen_hi - gen_lo) / n + 1;
    x = gen_desc ? gen_hi + $urandom_range(0, int'(step_max))
                 : gen_lo - $urandom_range(0, int'(step_max));
    for (int i = 0; i < n; i++) begin
      queue_eval(sat_q(x), close && (i == n - 1));
      if (gen_desc) x -= longint'($urandom) % (2 * stride + 1);
      else x += longint'($urandom) % (2 * stride + 1);
    end
  endfunction

  // Wait until every transaction is in and every result out, then let loads settle
  task automatic wait_idle();
    while (accepted_items != queued_items || predicted_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_knot_count(input logic [KNOT_COUNT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= KNOT_COUNT_ADDR;
    pwdata <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    knot_count_reg = value;
    n_settings++;
  endtask

  // Input driver: one transaction at a time, random gap before each
  always @(posedge clk) begin : drive_inputs
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        apply_item(tx_item);
        accepted_items++;
        busy = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_rush = !tx_rush;
        tx_gap = tx_rush ? 0 : $urandom_range(0, 8);
      end
      if (!busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (spline_items.size() != 0) begin
          tx_item = spline_items.pop_front();
          in_mode <= tx_item.mode;
          in_entry_index <= tx_item.idx;
          in_knot_value <= tx_item.knot;
          in_coef_const <= tx_item.a;
          in_coef_linear <= tx_item.b;
          in_coef_square <= tx_item.c;
          in_coef_cube <= tx_item.d;
          in_x_value <= tx_item.x;
          in_last_in_batch <= tx_item.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against oldest prediction, random back-pressure
  always @(posedge clk) begin : watch_results
    point_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (predicted_points.size() == 0) begin
          $error("unexpected result: y_value %0d segment_used %0d", out_y_value,
                 out_segment_used);
          n_errors++;
        end else begin
          want = predicted_points.pop_front();
          if (want.ovf) n_saturated++;
          if (out_y_value !== want.y) begin
            $error("y_value: expected %0d, got %0d", want.y, out_y_value);
            n_errors++;
          end
          if (out_segment_used !== want.seg) begin
            $error("segment_used: expected %0d, got %0d", want.seg, out_segment_used);
            n_errors++;
          end
          if (out_overflow !== want.ovf) begin
            $error("overflow: expected %0d, got %0d", want.ovf, out_overflow);
            n_errors++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, out_last_out);
            n_errors++;
          end
        end
        if ($urandom_range(0, 29) == 0) rx_rush = !rx_rush;
        rx_wait = rx_rush ? 0 : $urandom_range(0, 8);
        // one long hold-off while the sender still has plenty queued
        if (!rx_hold_done && n_results >= 150 && spline_items.size() > 8) begin
          rx_hold = HOLD_CYCLES;
          rx_hold_done = 1'b1;
        end
      end else if (rx_hold != 0) begin
        rx_hold--;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready <= (rx_hold == 0) && (rx_wait == 0);
    end
  end

  initial begin : stimulus
    int           k, start, nb;
    logic [KNOT_COUNT_W-1:0] cval;
    table_order_t order;
    int           cbits;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: small ascending table, evaluated first at the reset count
    queue_load(0, -2 * FX_ONE, FX_ONE, FX_ONE / 2, -FX_ONE / 4, FX_ONE / 8);
    queue_load(1, 0, -FX_ONE, FX_ONE / 4, FX_ONE / 2, -FX_ONE / 8);
    queue_load(2, 2 * FX_ONE, FX_ONE / 2, -FX_ONE, FX_ONE / 8, FX_ONE / 4);
    queue_load(NK - 1, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN);
    queue_eval(4 * FX_ONE, 1'b0);
    wait_idle();
    write_knot_count(3);

    // extremes of x, exact knots, end segment
    queue_eval(FX_MIN, 1'b0);
    queue_eval(-2 * FX_ONE, 1'b0);
    queue_eval(0, 1'b0);
    queue_eval(2 * FX_ONE, 1'b0);
    queue_eval(FX_MAX, 1'b1);
    // saturating coefficients
    queue_load(1, 0, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    queue_eval(FX_ONE, 1'b0);
    queue_eval(-1, 1'b1);
    // descending knots
    queue_load(0, 2 * FX_ONE, FX_ONE, -FX_ONE, FX_ONE / 2, FX_ONE / 4);
    queue_load(1, 0, FX_ONE / 2, FX_ONE, -FX_ONE / 2, FX_ONE / 8);
    queue_load(2, -2 * FX_ONE, -FX_ONE, FX_ONE / 4, FX_ONE, -FX_ONE / 4);
    queue_eval(3 * FX_ONE, 1'b0);
    queue_eval(0, 1'b0);
    queue_eval(-3 * FX_ONE, 1'b1);
    // equal first knots count as ascending; keep segment 1 for the next setting
    queue_load(1, 2 * FX_ONE, FX_ONE / 2, FX_ONE, -FX_ONE / 2, FX_ONE / 8);
    queue_eval(2 * FX_ONE, 1'b0);
    wait_idle();
    // kept position now beyond the last segment
    write_knot_count(2);
    queue_eval(0, 1'b1);

    // Random phases: new count, fresh table, swept batches mixed with noise
    start = queued_items;
    while (queued_items - start < 550) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: cval = KNOT_COUNT_W'(2);
        1: cval = KNOT_COUNT_W'(NK);
        2: cval = KNOT_COUNT_W'($urandom_range(0, 1));
        3: cval = KNOT_COUNT_W'($urandom_range(NK + 1, (1 << KNOT_COUNT_W) - 1));
        default: cval = KNOT_COUNT_W'($urandom_range(3, 16));
      endcase
      write_knot_count(cval);
      k = active_knots(cval);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: order = ORD_ASC;
        4, 5, 6: order = ORD_DESC;
        7: order = ORD_EQ_FIRST;
        default: order = ORD_SCRAMBLED;
      endcase
      cbits = ($urandom_range(0, 4) == 0) ? VB : 19;
      fill_table(k, order, cbits);
      nb = $urandom_range(1, 3);
      for (int b = 0; b < nb; b++) begin
        queue_batch($urandom_range(2, 12), $urandom_range(0, 5) != 0);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 3) == 0) begin
            cval = KNOT_COUNT_W'($urandom_range(0, k - 1));
            queue_load(int'(cval), VB'(gen_knot[cval]), rand_q(cbits), rand_q(cbits),
                       rand_q(cbits), rand_q(cbits));
          end else if ($urandom_range(0, 1) == 0) begin
            queue_eval(rand_q(VB), $urandom_range(0, 7) == 0);
          end else begin
            queue_eval(sat_q(gen_lo + longint'($urandom) % (gen_hi - gen_lo + 1)),
                       $urandom_range(0, 7) == 0);
          end
        end
      end
    end

    wait_idle();
    $display("covered %0d table loads and %0d evaluations over %0d knot_count settings",
             n_loads, n_evals, n_settings);
    $display("%0d results saturated; long receiver hold-off applied: %0d",
             n_saturated, rx_hold_done);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
